[design/dpes_pkg.sv]
// Shared types and constants for the double-ended priority set.
`default_nettype none
package dpes_pkg;

	localparam int CAPACITY_DEF    = 256;
	localparam int KEY_BITS_DEF    = 16;
	localparam int WEIGHT_BITS_DEF = 16;

	localparam int FIELD_KEY_BITS    = 16;
	localparam int FIELD_WEIGHT_BITS = 16;
	localparam int SUM_BITS          = 24;
	localparam int COUNT_OUT_BITS    = 9;
	localparam int IN_TDATA_BITS     = 40;
	localparam int OUT_TDATA_BITS    = 64;

	localparam int TREE_FANIN = 16;

	localparam logic [1:0] WAIT_LAST = 2'd3;

	localparam logic [1:0] ACT_INSERT  = 2'd0;
	localparam logic [1:0] ACT_REM_MAX = 2'd1;
	localparam logic [1:0] ACT_REM_MIN = 2'd2;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_DUP   = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WAIT,
		S_APPLY
	} fsm_t;

	typedef struct packed {
		logic ins;
		logic rm_min;
	} cell_op_t;

endpackage
`default_nettype wire

[design/double_ended_priority_set.sv]
// Double-ended priority set: sorted chain of entry cells with stream ports.
// Input channel s_t*: one action per transfer (insert, remove largest, remove
// smallest). Output channel m_t*: one result per action with status, entry
// count, weight sum and key sum after the action.
// Each action runs these steps from input transfer to result valid: the transfer
// loads the command, each cell's match and top-entry word is registered, the
// registered OR tree finds a duplicate key and the largest entry, and the apply
// step shifts the entries across the cell chain.
// A new input transfer is taken in the cycle after the previous action applied,
// so actions do not overlap: the next one waits until the last has applied.
// The result sits in an output register; the next action is accepted and
// processed while it waits, and holds in its apply cycle until the receiver
// takes the earlier result.
// Reset clears the count and both sums, so the set starts empty; cell
// contents are not cleared and are only read below the count.
`default_nettype none
module double_ended_priority_set #(
	parameter int CAPACITY    = dpes_pkg::CAPACITY_DEF,
	parameter int KEY_BITS    = dpes_pkg::KEY_BITS_DEF,
	parameter int WEIGHT_BITS = dpes_pkg::WEIGHT_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	// action[1:0], entry_key[17:2], entry_weight[33:18], zero pad
	input  wire  [dpes_pkg::IN_TDATA_BITS-1:0]   s_tdata,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	// status[1:0], entry_count[10:2], weight_sum[34:11], key_sum[58:35], zero pad
	output logic [dpes_pkg::OUT_TDATA_BITS-1:0]  m_tdata
);
	import dpes_pkg::*;

	localparam int COUNT_BITS = $clog2(CAPACITY + 1);
	localparam int D          = KEY_BITS + WEIGHT_BITS + 1;

	cell_op_t               op;
	logic [KEY_BITS-1:0]    cmd_key;
	logic [WEIGHT_BITS-1:0] cmd_weight;
	logic [COUNT_BITS-1:0]  held_count;
	logic [KEY_BITS-1:0]    cell_key    [CAPACITY];
	logic [WEIGHT_BITS-1:0] cell_weight [CAPACITY];
	logic                   cell_lt     [CAPACITY];
	logic [D-1:0]           leaf        [CAPACITY];
	logic [D-1:0]           root;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_BITS-1:0]    lk, rk;
		logic [WEIGHT_BITS-1:0] lw, rw;
		logic                   llt;
		if (i == 0) begin : g_first
			assign lk  = '0;
			assign lw  = '0;
			assign llt = 1'b1;
		end else begin : g_mid
			assign lk  = cell_key[i-1];
			assign lw  = cell_weight[i-1];
			assign llt = cell_lt[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rk = '0;
			assign rw = '0;
		end else begin : g_inner
			assign rk = cell_key[i+1];
			assign rw = cell_weight[i+1];
		end
		dpes_cell #(
			.KEY_BITS   (KEY_BITS),
			.WEIGHT_BITS(WEIGHT_BITS),
			.COUNT_BITS (COUNT_BITS),
			.INDEX      (i)
		) u_cell (
			.clk         (clk),
			.op          (op),
			.cmd_key     (cmd_key),
			.cmd_weight  (cmd_weight),
			.held_count  (held_count),
			.left_key    (lk),
			.left_weight (lw),
			.left_lt     (llt),
			.right_key   (rk),
			.right_weight(rw),
			.cell_key    (cell_key[i]),
			.cell_weight (cell_weight[i]),
			.cell_lt     (cell_lt[i]),
			.contrib     (leaf[i])
		);
	end

	dpes_or_tree #(
		.N(CAPACITY),
		.D(D)
	) u_tree (
		.clk (clk),
		.leaf(leaf),
		.root(root)
	);

	dpes_ctrl #(
		.CAPACITY   (CAPACITY),
		.KEY_BITS   (KEY_BITS),
		.WEIGHT_BITS(WEIGHT_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.op           (op),
		.cmd_key      (cmd_key),
		.cmd_weight   (cmd_weight),
		.held_count   (held_count),
		.root_eq      (root[D-1]),
		.top_key      (root[D-2:WEIGHT_BITS]),
		.top_weight   (root[WEIGHT_BITS-1:0]),
		.bottom_key   (cell_key[0]),
		.bottom_weight(cell_weight[0])
	);

endmodule
`default_nettype wire

[design/dpes_cell.sv]
// One storage cell of the sorted chain: holds one entry and shifts with its neighbors.
`default_nettype none
module dpes_cell #(
	parameter int KEY_BITS    = 16,
	parameter int WEIGHT_BITS = 16,
	parameter int COUNT_BITS  = 9,
	parameter int INDEX       = 0
) (
	input  wire                            clk,
	input  dpes_pkg::cell_op_t             op,
	input  wire  [KEY_BITS-1:0]            cmd_key,
	input  wire  [WEIGHT_BITS-1:0]         cmd_weight,
	input  wire  [COUNT_BITS-1:0]          held_count,
	input  wire  [KEY_BITS-1:0]            left_key,
	input  wire  [WEIGHT_BITS-1:0]         left_weight,
	input  wire                            left_lt,
	input  wire  [KEY_BITS-1:0]            right_key,
	input  wire  [WEIGHT_BITS-1:0]         right_weight,
	output logic [KEY_BITS-1:0]            cell_key,
	output logic [WEIGHT_BITS-1:0]         cell_weight,
	output logic                           cell_lt,
	output logic [KEY_BITS+WEIGHT_BITS:0]  contrib
);
	import dpes_pkg::*;

	logic [KEY_BITS-1:0]           key_q;
	logic [WEIGHT_BITS-1:0]        weight_q;
	logic [KEY_BITS+WEIGHT_BITS:0] contrib_q;
	logic                          own_valid;
	logic                          own_eq;
	logic                          own_top;

	always_comb begin
		own_valid = COUNT_BITS'(INDEX) < held_count;
		cell_lt   = own_valid && (key_q < cmd_key);
		own_eq    = own_valid && (key_q == cmd_key);
		own_top   = COUNT_BITS'(INDEX + 1) == held_count;
	end

	always_ff @(posedge clk) begin
		contrib_q <= {own_eq, own_top ? key_q : '0, own_top ? weight_q : '0};
		if (op.ins) begin
			if (!cell_lt) begin
				if (left_lt) begin
					key_q    <= cmd_key;
					weight_q <= cmd_weight;
				end else begin
					key_q    <= left_key;
					weight_q <= left_weight;
				end
			end
		end else if (op.rm_min) begin
			key_q    <= right_key;
			weight_q <= right_weight;
		end
	end

	assign cell_key    = key_q;
	assign cell_weight = weight_q;
	assign contrib     = contrib_q;

endmodule
`default_nettype wire

[design/dpes_or_tree.sv]
// Registered three-level OR reduction over the cell match and top-entry words.
`default_nettype none
module dpes_or_tree #(
	parameter int N = 256,
	parameter int D = 33
) (
	input  wire          clk,
	input  wire  [D-1:0] leaf [N],
	output logic [D-1:0] root
);
	import dpes_pkg::*;

	localparam int F  = TREE_FANIN;
	localparam int N1 = (N + F - 1) / F;
	localparam int N2 = (N1 + F - 1) / F;

	logic [D-1:0] pad0 [N1*F];
	logic [D-1:0] l1_d [N1];
	logic [D-1:0] l1_q [N1];
	logic [D-1:0] pad1 [N2*F];
	logic [D-1:0] l2_d [N2];
	logic [D-1:0] l2_q [N2];
	logic [D-1:0] pad2 [F];
	logic [D-1:0] root_d;
	logic [D-1:0] root_q;

	for (genvar i = 0; i < N1 * F; i++) begin : g_pad0
		if (i < N) begin : g_use
			assign pad0[i] = leaf[i];
		end else begin : g_zero
			assign pad0[i] = '0;
		end
	end

	for (genvar g = 0; g < N1; g++) begin : g_l1
		always_comb begin
			l1_d[g] = '0;
			for (int j = 0; j < F; j++) begin
				l1_d[g] = l1_d[g] | pad0[g*F + j];
			end
		end
		always_ff @(posedge clk) begin
			l1_q[g] <= l1_d[g];
		end
	end

	for (genvar i = 0; i < N2 * F; i++) begin : g_pad1
		if (i < N1) begin : g_use
			assign pad1[i] = l1_q[i];
		end else begin : g_zero
			assign pad1[i] = '0;
		end
	end

	for (genvar g = 0; g < N2; g++) begin : g_l2
		always_comb begin
			l2_d[g] = '0;
			for (int j = 0; j < F; j++) begin
				l2_d[g] = l2_d[g] | pad1[g*F + j];
			end
		end
		always_ff @(posedge clk) begin
			l2_q[g] <= l2_d[g];
		end
	end

	for (genvar i = 0; i < F; i++) begin : g_pad2
		if (i < N2) begin : g_use
			assign pad2[i] = l2_q[i];
		end else begin : g_zero
			assign pad2[i] = '0;
		end
	end

	always_comb begin
		root_d = '0;
		for (int j = 0; j < F; j++) begin
			root_d = root_d | pad2[j];
		end
	end

	always_ff @(posedge clk) begin
		root_q <= root_d;
	end

	assign root = root_q;

endmodule
`default_nettype wire

[design/dpes_ctrl.sv]
// Sequencer: stream handshakes, entry count, running sums and result register.
`default_nettype none
module dpes_ctrl #(
	parameter int CAPACITY    = 256,
	parameter int KEY_BITS    = 16,
	parameter int WEIGHT_BITS = 16,
	parameter int COUNT_BITS  = 9
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire  [dpes_pkg::IN_TDATA_BITS-1:0]   s_tdata,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [dpes_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
	output dpes_pkg::cell_op_t                   op,
	output logic [KEY_BITS-1:0]                  cmd_key,
	output logic [WEIGHT_BITS-1:0]               cmd_weight,
	output logic [COUNT_BITS-1:0]                held_count,
	input  wire                                  root_eq,
	input  wire  [KEY_BITS-1:0]                  top_key,
	input  wire  [WEIGHT_BITS-1:0]               top_weight,
	input  wire  [KEY_BITS-1:0]                  bottom_key,
	input  wire  [WEIGHT_BITS-1:0]               bottom_weight
);
	import dpes_pkg::*;

	fsm_t                     state_q, state_d;
	logic [1:0]               wait_q, wait_d;
	logic [1:0]               action_q;
	logic [KEY_BITS-1:0]      key_q;
	logic [WEIGHT_BITS-1:0]   weight_q;
	logic [COUNT_BITS-1:0]    count_q, count_d;
	logic [SUM_BITS-1:0]      wsum_q, wsum_d;
	logic [SUM_BITS-1:0]      ksum_q, ksum_d;
	logic                     m_tvalid_q;
	logic [OUT_TDATA_BITS-1:0] m_tdata_q;
	status_t                  status;
	logic                     accept;
	logic                     apply_go;
	logic                     is_full;
	logic                     is_empty;
	logic                     do_ins;
	logic                     do_rm;
	logic [KEY_BITS-1:0]      rm_key;
	logic [WEIGHT_BITS-1:0]   rm_weight;

	assign s_tready = state_q == S_IDLE;
	assign accept   = s_tvalid && s_tready;
	assign is_full  = count_q == COUNT_BITS'(CAPACITY);
	assign is_empty = count_q == '0;

	always_comb begin
		status    = ST_DONE;
		do_ins    = 1'b0;
		do_rm     = 1'b0;
		rm_key    = bottom_key;
		rm_weight = bottom_weight;
		case (action_q)
			ACT_INSERT: begin
				if (root_eq) begin
					status = ST_DUP;
				end else if (is_full) begin
					status = ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			ACT_REM_MAX: begin
				rm_key    = top_key;
				rm_weight = top_weight;
				if (is_empty) begin
					status = ST_EMPTY;
				end else begin
					do_rm = 1'b1;
				end
			end
			ACT_REM_MIN: begin
				if (is_empty) begin
					status = ST_EMPTY;
				end else begin
					do_rm = 1'b1;
				end
			end
			default: begin
				status = ST_DONE;
			end
		endcase
	end

	always_comb begin
		state_d  = state_q;
		wait_d   = wait_q;
		apply_go = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_WAIT;
					wait_d  = '0;
				end
			end
			S_WAIT: begin
				wait_d = wait_q + 2'd1;
				if (wait_q == WAIT_LAST) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				if (!m_tvalid_q || m_tready) begin
					apply_go = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		count_d = count_q;
		wsum_d  = wsum_q;
		ksum_d  = ksum_q;
		if (do_ins) begin
			count_d = count_q + 1'b1;
			wsum_d  = wsum_q + SUM_BITS'(weight_q);
			ksum_d  = ksum_q + SUM_BITS'(key_q);
		end else if (do_rm) begin
			count_d = count_q - 1'b1;
			wsum_d  = wsum_q - SUM_BITS'(rm_weight);
			ksum_d  = ksum_q - SUM_BITS'(rm_key);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			wait_q     <= '0;
			count_q    <= '0;
			wsum_q     <= '0;
			ksum_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wait_q  <= wait_d;
			if (apply_go) begin
				count_q    <= count_d;
				wsum_q     <= wsum_d;
				ksum_q     <= ksum_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= s_tdata[1:0];
			key_q    <= KEY_BITS'(s_tdata[17:2]);
			weight_q <= WEIGHT_BITS'(s_tdata[33:18]);
		end
		if (apply_go) begin
			m_tdata_q <= OUT_TDATA_BITS'({ksum_d, wsum_d, COUNT_OUT_BITS'(count_d), status});
		end
	end

	assign op.ins     = apply_go && do_ins;
	assign op.rm_min  = apply_go && do_rm && (action_q == ACT_REM_MIN);
	assign cmd_key    = key_q;
	assign cmd_weight = weight_q;
	assign held_count = count_q;
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_BITS'(CAPACITY))
		else $error("entry count above capacity");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		op.ins |=> count_q == COUNT_BITS'($past(count_q) + 1'b1))
		else $error("insert did not advance the count");

	a_full_report: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && (m_tdata_q[1:0] == ST_FULL)
		|-> m_tdata_q[10:2] == COUNT_OUT_BITS'(CAPACITY))
		else $error("full status without full count");

	a_empty_report: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && (m_tdata_q[1:0] == ST_EMPTY) |-> m_tdata_q[10:2] == '0)
		else $error("empty status with nonzero count");

endmodule
`default_nettype wire
